// ===== hw/rtl/pbca_pkg.sv =====
// Shared types, constants and codes of the pseudo-Boolean constraint accumulator.
package pbca_pkg;

	localparam int ATOM_COUNT = 1024;
	localparam int COEF_BITS  = 24;

	localparam int ATOM_W     = 10;
	localparam int IN_COEF_W  = 24;
	localparam int DEG_W      = 32;
	localparam int DEG_EXT_W  = DEG_W + 2;
	localparam int CNT_OUT_W  = 11;
	localparam int ADDR_W     = (ATOM_COUNT > 1) ? $clog2(ATOM_COUNT) : 1;
	localparam int CNT_W      = $clog2(ATOM_COUNT + 1);
	localparam int RAM_W      = COEF_BITS + 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ATOM_COUNT - 1);

	// Coefficient limits at the stored width and widened for the input check.
	localparam logic [COEF_BITS-1:0] COEF_MAX_C = {1'b0, {(COEF_BITS-1){1'b1}}};
	localparam logic [COEF_BITS-1:0] COEF_MIN_C = {1'b1, {(COEF_BITS-1){1'b0}}};
	localparam logic signed [32:0] COEF_MAX_W = 33'((64'sd1 <<< (COEF_BITS - 1)) - 64'sd1);
	localparam logic signed [32:0] COEF_MIN_W = -COEF_MAX_W - 33'sd1;

	localparam logic [DEG_W-1:0] DEG_MAX = {1'b0, {(DEG_W-1){1'b1}}};
	localparam logic [DEG_W-1:0] DEG_MIN = {1'b1, {(DEG_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_DEGREE  = 2'd1,
		CMD_LITERAL = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC
	} back_state_t;

	// A classified item as it waits in the queue.
	typedef struct packed {
		cmd_t                        cmd;
		logic [ATOM_W-1:0]           atom;
		logic                        in_range;
		logic signed [COEF_BITS-1:0] coef;
		logic [COEF_BITS-1:0]        mag;
		logic                        sat_ovf;
		logic signed [DEG_W-1:0]     amount;
	} pbca_item_t;

	typedef struct packed {
		logic [ATOM_W-1:0]           atom;
		logic signed [IN_COEF_W-1:0] coef;
		logic                        present;
		logic signed [DEG_W-1:0]     degree;
		logic [CNT_OUT_W-1:0]        count;
		logic                        overflow;
	} pbca_result_t;

endpackage

// ===== hw/rtl/pb_constraint_accumulate.sv =====
// Pseudo-Boolean constraint accumulator: top level tying front end, queue and back end together.
//
// Items arrive on the s_ stream: s_tuser carries the command (clear, add degree amount,
// add literal, read entry) and s_tdata the atom, coefficient and degree amount. Every
// item gives exactly one result item on the m_ stream with the atom's coefficient and
// present flag, the degree, the literal count and the overflow flag after the step.
// The front end saturates and classifies each item and places it in a two-entry queue.
// The back end does one read-modify-write of the table RAM per item: a read cycle and an
// execute cycle. It takes the next item from the queue only once the result of the last
// one is in the output register. An accepted item passes through the queue entry, the item
// register with the RAM read data, and the output register.
// A clear item sweeps the present flags of all ATOM_COUNT entries, one per cycle, and
// resets degree and count. After reset the same sweep runs with s_tready low; degree and
// count are zero.
// When the receiver stalls, the result waits in the output register; the back end halts
// on its next result and the queue takes up to two more items before s_tready drops.
module pb_constraint_accumulate import pbca_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// atom [9:0], coefficient [33:10], degree_amount [65:34], zero [71:66]
	input  logic [71:0] s_tdata,
	// command [1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// atom_out [9:0], coefficient_out [33:10], present [34], degree [66:35],
	// literal_count [77:67], overflow [78], zero [79]
	output logic [79:0] m_tdata
);

	logic         q_valid;
	pbca_item_t   q_item;
	logic         q_pop;
	logic         init_busy;
	pbca_result_t result;

	pbca_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.hold_in  (init_busy),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	pbca_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_result  (result)
	);

	assign m_tdata = {1'b0, result.overflow, result.count, result.degree, result.present,
		result.coef, result.atom};

endmodule

// ===== hw/rtl/pbca_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pbca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/pbca_front.sv =====
// Front end: accepts items, saturates and classifies them, and queues them for the back end.
module pbca_front import pbca_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [71:0] s_tdata,
	input  logic [1:0] s_tuser,
	input  logic       hold_in,
	output logic       q_valid,
	output pbca_item_t q_item,
	input  logic       q_pop
);

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	pbca_item_t               entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q;
	logic [PTR_W-1:0]         rd_ptr_q;
	logic [FILL_W-1:0]        fill_q;

	logic [IN_COEF_W-1:0]     in_coef;
	logic signed [32:0]       coef_w;
	logic [COEF_BITS-1:0]     coef_sat;
	logic                     coef_over;
	logic [COEF_BITS:0]       coef_neg;
	pbca_item_t               item_in;
	logic                     push;
	logic                     pop;

	assign in_coef = s_tdata[33:10];
	assign coef_w  = {{(33-IN_COEF_W){in_coef[IN_COEF_W-1]}}, in_coef};

	always_comb begin
		coef_over = 1'b0;
		if (coef_w > COEF_MAX_W) begin
			coef_sat  = COEF_MAX_C;
			coef_over = 1'b1;
		end else if (coef_w < COEF_MIN_W) begin
			coef_sat  = COEF_MIN_C;
			coef_over = 1'b1;
		end else begin
			coef_sat = coef_w[COEF_BITS-1:0];
		end
		coef_neg = -{coef_sat[COEF_BITS-1], coef_sat};

		item_in.cmd      = cmd_t'(s_tuser);
		item_in.atom     = s_tdata[9:0];
		item_in.in_range = ({7'd0, s_tdata[9:0]} < 17'(ATOM_COUNT));
		item_in.coef     = coef_sat;
		item_in.mag      = coef_sat[COEF_BITS-1] ? coef_neg[COEF_BITS-1:0] : coef_sat;
		// Only the literal command reports a saturated coefficient as overflow.
		item_in.sat_ovf  = coef_over && (cmd_t'(s_tuser) == CMD_LITERAL);
		item_in.amount   = s_tdata[65:34];
	end

	assign s_tready = (fill_q != FILL_W'(QUEUE_DEPTH)) && !hold_in;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (fill_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   fill_q <= FILL_W'(fill_q + 1'b1);
				2'b01:   fill_q <= FILL_W'(fill_q - 1'b1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/pbca_back.sv =====
// Back end: read-modify-write of the coefficient table, degree and count, and the result register.
module pbca_back import pbca_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  pbca_item_t   q_item,
	output logic         q_pop,
	output logic         init_busy,
	output logic         m_valid,
	input  logic         m_ready,
	output pbca_result_t m_result
);

	back_state_t          state_q;
	back_state_t          state_d;
	logic [ADDR_W-1:0]    sweep_addr_q;
	logic                 emit_q;
	pbca_item_t           item_q;
	logic [DEG_W-1:0]     deg_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	pbca_result_t         out_q;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [RAM_W-1:0]     ram_wdata;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [RAM_W-1:0]     ram_rdata;

	logic                 out_free;
	logic                 sweep_last;
	logic                 start_clear;
	logic                 load_exec;
	logic                 load_clear;

	logic signed [COEF_BITS-1:0] old_c;
	logic                 old_p;
	logic [COEF_BITS:0]   ao_ext;
	logic [COEF_BITS-1:0] ao;
	logic [COEF_BITS:0]   sum;
	logic [COEF_BITS-1:0] sum_sat;
	logic                 sum_ovf;
	logic [COEF_BITS-1:0] min_mag;
	logic [DEG_EXT_W-1:0] deg_add;
	logic [DEG_EXT_W-1:0] deg_sum;
	logic [DEG_W-1:0]     deg_sat;
	logic                 deg_ovf;
	logic                 deg_upd;
	logic                 new_p;
	logic [COEF_BITS-1:0] new_c;
	logic                 tbl_wr;
	logic                 cnt_inc;
	logic                 cnt_dec;
	logic                 ovf;
	logic [DEG_W-1:0]     deg_new;
	logic [CNT_W-1:0]     cnt_new;
	logic [31:0]          coef_wide;
	logic [16:0]          cnt_wide;

	function automatic logic [ADDR_W-1:0] atom_addr(input logic [ATOM_W-1:0] atom);
		logic [16:0] ext;
		ext = {{(17-ATOM_W){1'b0}}, atom};
		return ext[ADDR_W-1:0];
	endfunction

	pbca_ram #(
		.WIDTH (RAM_W),
		.DEPTH (ATOM_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free   = !out_valid_q || m_ready;
	assign sweep_last = (sweep_addr_q == LAST_ADDR);

	// Entry update: the table word holds the present flag above the coefficient.
	always_comb begin
		old_c   = ram_rdata[COEF_BITS-1:0];
		old_p   = ram_rdata[COEF_BITS] && item_q.in_range;
		ao_ext  = old_c[COEF_BITS-1] ? -{old_c[COEF_BITS-1], old_c} : {old_c[COEF_BITS-1], old_c};
		ao      = ao_ext[COEF_BITS-1:0];
		sum     = {old_c[COEF_BITS-1], old_c} + {item_q.coef[COEF_BITS-1], item_q.coef};
		sum_ovf = sum[COEF_BITS] ^ sum[COEF_BITS-1];
		sum_sat = sum_ovf ? (sum[COEF_BITS] ? COEF_MIN_C : COEF_MAX_C) : sum[COEF_BITS-1:0];
		min_mag = (item_q.mag < ao) ? item_q.mag : ao;

		new_p   = old_p;
		new_c   = old_c;
		tbl_wr  = 1'b0;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		deg_upd = 1'b0;
		deg_add = '0;
		ovf     = item_q.sat_ovf;

		case (item_q.cmd)
			CMD_DEGREE: begin
				deg_upd = 1'b1;
				deg_add = {{(DEG_EXT_W-DEG_W){item_q.amount[DEG_W-1]}}, item_q.amount};
			end
			CMD_LITERAL: begin
				if (item_q.in_range && (item_q.coef != '0)) begin
					tbl_wr = 1'b1;
					if (!old_p) begin
						new_p   = 1'b1;
						new_c   = item_q.coef;
						cnt_inc = 1'b1;
					end else if (item_q.coef[COEF_BITS-1] == old_c[COEF_BITS-1]) begin
						new_c = sum_sat;
						ovf   = ovf | sum_ovf;
					end else if (item_q.mag == ao) begin
						// Full cancellation removes the entry.
						new_p   = 1'b0;
						cnt_dec = 1'b1;
						deg_upd = 1'b1;
						deg_add = -{{(DEG_EXT_W-COEF_BITS){1'b0}}, item_q.mag};
					end else begin
						new_c   = sum[COEF_BITS-1:0];
						deg_upd = 1'b1;
						deg_add = -{{(DEG_EXT_W-COEF_BITS){1'b0}}, min_mag};
					end
				end
			end
			default: begin
			end
		endcase

		deg_sum = {{(DEG_EXT_W-DEG_W){deg_q[DEG_W-1]}}, deg_q} + deg_add;
		deg_ovf = !((deg_sum[DEG_EXT_W-1] == deg_sum[DEG_EXT_W-2]) &&
			(deg_sum[DEG_EXT_W-2] == deg_sum[DEG_W-1]));
		deg_sat = deg_ovf ? (deg_sum[DEG_EXT_W-1] ? DEG_MIN : DEG_MAX) : deg_sum[DEG_W-1:0];
		if (deg_upd) begin
			deg_new = deg_sat;
			ovf     = ovf | deg_ovf;
		end else begin
			deg_new = deg_q;
		end

		if (cnt_inc) begin
			cnt_new = CNT_W'(cnt_q + 1'b1);
		end else if (cnt_dec) begin
			cnt_new = CNT_W'(cnt_q - 1'b1);
		end else begin
			cnt_new = cnt_q;
		end

		coef_wide = new_p ? {{(32-COEF_BITS){new_c[COEF_BITS-1]}}, new_c} : 32'd0;
		cnt_wide  = {{(17-CNT_W){1'b0}}, cnt_new};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_last && (!emit_q || out_free)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					state_d = (q_item.cmd == CMD_CLEAR) ? ST_SWEEP : ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_SWEEP;
		endcase
	end

	always_comb begin
		q_pop       = 1'b0;
		ram_re      = 1'b0;
		ram_raddr   = atom_addr(q_item.atom);
		ram_we      = 1'b0;
		ram_waddr   = atom_addr(item_q.atom);
		ram_wdata   = {new_p, new_c};
		start_clear = 1'b0;
		load_exec   = 1'b0;
		load_clear  = 1'b0;
		case (state_q)
			ST_SWEEP: begin
				ram_we     = 1'b1;
				ram_waddr  = sweep_addr_q;
				ram_wdata  = '0;
				load_clear = sweep_last && emit_q && out_free;
			end
			ST_IDLE: begin
				q_pop = q_valid;
				if (q_valid) begin
					if (q_item.cmd == CMD_CLEAR) begin
						start_clear = 1'b1;
					end else begin
						ram_re = 1'b1;
					end
				end
			end
			ST_EXEC: begin
				load_exec = out_free;
				ram_we    = out_free && tbl_wr;
			end
			default: begin
			end
		endcase
	end

	assign init_busy = (state_q == ST_SWEEP) && !emit_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (load_exec) begin
			out_q.atom     <= item_q.atom;
			out_q.coef     <= coef_wide[IN_COEF_W-1:0];
			out_q.present  <= new_p;
			out_q.degree   <= deg_new;
			out_q.count    <= cnt_wide[CNT_OUT_W-1:0];
			out_q.overflow <= ovf;
		end else if (load_clear) begin
			out_q.atom     <= item_q.atom;
			out_q.coef     <= '0;
			out_q.present  <= 1'b0;
			out_q.degree   <= '0;
			out_q.count    <= '0;
			out_q.overflow <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_addr_q <= '0;
			emit_q       <= 1'b0;
			deg_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SWEEP) begin
				if (!sweep_last) begin
					sweep_addr_q <= ADDR_W'(sweep_addr_q + 1'b1);
				end else if (state_d == ST_IDLE) begin
					sweep_addr_q <= '0;
					emit_q       <= 1'b0;
				end
			end
			if (start_clear) begin
				emit_q <= 1'b1;
				deg_q  <= '0;
				cnt_q  <= '0;
			end else if (load_exec) begin
				deg_q <= deg_new;
				cnt_q <= cnt_new;
			end
			if (load_exec || load_clear) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_valid  = out_valid_q;
	assign m_result = out_q;

endmodule
